[sv/rkbc_pkg.sv]
// Shared constants, types and helper functions of the rolling key byte cipher.
package rkbc_pkg;

   localparam int MODE_W     = 2;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int LEN_W      = 4;
   localparam int RING_DEPTH = 10;
   localparam int IDX_W      = $clog2(RING_DEPTH);

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_HDR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ENC = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DEC = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_DATA    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TAKEN   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_OK      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FAIL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

   // Ring geometry.
   localparam logic [LEN_W-1:0] LEN_SHORT     = 4'd9;
   localparam logic [LEN_W-1:0] LEN_LONG      = 4'd10;
   localparam logic [LEN_W-1:0] DEPTH_L       = LEN_W'(RING_DEPTH);
   localparam logic [LEN_W-1:0] LEN_SEL_COUNT = 4'd5;

   // Arithmetic constants.
   localparam int CHECK_STEP = 30;
   localparam int CHECK_MUL  = 9;
   localparam int KEY_ADD_I  = (CHECK_STEP * CHECK_MUL) % 256;
   localparam logic [BYTE_W-1:0] KEY_ADD = BYTE_W'(KEY_ADD_I);

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              header_start;
      logic [BYTE_W-1:0] data_in;
   } item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_out;
      logic [STATUS_W-1:0] status;
      logic [LEN_W-1:0]    key_size;
   } result_type;

   // Expected check byte: (prev * 9) xor (factor * 30), modulo 256.
   function automatic logic [BYTE_W-1:0] check_byte(input logic [BYTE_W-1:0] prev,
                                                    input logic [LEN_W-1:0]  factor);
      logic [BYTE_W+3:0] prod;
      logic [LEN_W+4:0]  step;
      prod = (BYTE_W + 4)'(prev) * (BYTE_W + 4)'(CHECK_MUL);
      step = (LEN_W + 5)'(factor) * (LEN_W + 5)'(CHECK_STEP);
      return prod[BYTE_W-1:0] ^ step[BYTE_W-1:0];
   endfunction

endpackage

[sv/rkbc_req_if.sv]
// Request and response channel interfaces: valid/ready handshake with the item fields.
interface rkbc_req_if;
   import rkbc_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic              header_start;
   logic [BYTE_W-1:0] data_in;

   modport source (output valid, output mode, output header_start, output data_in,
                   input ready);
   modport sink   (input valid, input mode, input header_start, input data_in,
                   output ready);
endinterface

interface rkbc_rsp_if;
   import rkbc_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_out;
   logic [STATUS_W-1:0] status;
   logic [LEN_W-1:0]    key_size;

   modport source (output valid, output data_out, output status, output key_size,
                   input ready);
   modport sink   (input valid, input data_out, input status, input key_size,
                   output ready);
endinterface

[sv/rkbc_core.sv]
// Key ring state and the single-pass header/data transform for one item.
module rkbc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_en,
   input  rkbc_pkg::item_type   item,
   output rkbc_pkg::result_type res
);
   import rkbc_pkg::*;

   logic [BYTE_W-1:0] key_ring_ff [RING_DEPTH];
   logic [BYTE_W-1:0] key_ring_in [RING_DEPTH];
   logic [LEN_W-1:0]  ring_length_ff, ring_length_in;
   logic [LEN_W-1:0]  ring_position_ff, ring_position_in;
   logic [LEN_W-1:0]  header_count_ff, header_count_in;
   logic              header_open_ff, header_open_in;

   logic [LEN_W-1:0]  cnt_v;
   logic [LEN_W-1:0]  pos_v;
   logic [LEN_W-1:0]  next_v;
   logic [BYTE_W-1:0] key_v;
   logic              chk_ok;

   always_comb begin
      key_ring_in      = key_ring_ff;
      ring_length_in   = ring_length_ff;
      ring_position_in = ring_position_ff;
      header_count_in  = header_count_ff;
      header_open_in   = header_open_ff;
      res.data_out     = '0;
      res.status       = ST_IGNORED;
      cnt_v            = '0;
      pos_v            = '0;
      next_v           = '0;
      key_v            = '0;
      chk_ok           = 1'b0;

      case (item.mode)
         MODE_HDR: begin
            if (item.header_start || header_open_ff) begin
               cnt_v          = item.header_start ? '0 : header_count_ff;
               header_open_in = 1'b1;
               if (cnt_v >= DEPTH_L) begin
                  cnt_v = '0;
               end
               key_ring_in[cnt_v[IDX_W-1:0]] = item.data_in;
               cnt_v = cnt_v + 1'b1;
               if (cnt_v == LEN_SEL_COUNT) begin
                  ring_length_in = item.data_in[0] ? LEN_LONG : LEN_SHORT;
               end
               if (cnt_v < LEN_SEL_COUNT || cnt_v < ring_length_in) begin
                  header_count_in = cnt_v;
                  res.status      = ST_TAKEN;
               end else begin
                  // The last two ring bytes are check bytes chained from the one before.
                  if (ring_length_in == LEN_LONG) begin
                     chk_ok = (key_ring_in[9] == check_byte(key_ring_in[8], LEN_LONG + 1'b1))
                           && (key_ring_in[8] == check_byte(key_ring_in[7], LEN_LONG));
                  end else begin
                     chk_ok = (key_ring_in[8] == check_byte(key_ring_in[7], LEN_SHORT + 1'b1))
                           && (key_ring_in[7] == check_byte(key_ring_in[6], LEN_SHORT));
                  end
                  header_open_in   = 1'b0;
                  header_count_in  = '0;
                  ring_position_in = '0;
                  res.status       = chk_ok ? ST_OK : ST_FAIL;
               end
            end
         end
         MODE_ENC, MODE_DEC: begin
            if (!header_open_ff) begin
               pos_v = ring_position_ff;
               if (pos_v >= ring_length_ff || pos_v >= DEPTH_L) begin
                  pos_v = '0;
               end
               next_v = pos_v + 1'b1;
               if (next_v >= ring_length_ff || next_v >= DEPTH_L) begin
                  next_v = '0;
               end
               key_v = key_ring_ff[pos_v[IDX_W-1:0]]
                     ^ (key_ring_ff[next_v[IDX_W-1:0]] + KEY_ADD);
               key_ring_in[pos_v[IDX_W-1:0]] = key_v;
               ring_position_in = next_v;
               res.data_out = (item.mode == MODE_ENC) ? (item.data_in + key_v)
                                                      : (item.data_in - key_v);
               res.status   = ST_DATA;
            end
         end
         default: begin
            res.status = ST_IGNORED;
         end
      endcase

      res.key_size = ring_length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++) begin
            key_ring_ff[i] <= '0;
         end
         ring_length_ff   <= LEN_SHORT;
         ring_position_ff <= '0;
         header_count_ff  <= '0;
         header_open_ff   <= 1'b0;
      end else if (item_en) begin
         key_ring_ff      <= key_ring_in;
         ring_length_ff   <= ring_length_in;
         ring_position_ff <= ring_position_in;
         header_count_ff  <= header_count_in;
         header_open_ff   <= header_open_in;
      end
   end

   a_len_legal: assert property (@(posedge clock) disable iff (reset)
      ring_length_ff == LEN_SHORT || ring_length_ff == LEN_LONG)
      else $error("ring length left the 9/10 range");

   // A header may shorten the ring while it loads; the position is only
   // rewound when that header completes.
   a_pos_in_ring: assert property (@(posedge clock) disable iff (reset)
      !header_open_ff |-> ring_position_ff < ring_length_ff)
      else $error("ring position beyond ring length");

   a_hdr_close: assert property (@(posedge clock) disable iff (reset)
      item_en && (res.status == ST_OK || res.status == ST_FAIL)
      |=> !header_open_ff && ring_position_ff == '0 && header_count_ff == '0)
      else $error("header completion did not close the header and rewind");

   a_data_blocked: assert property (@(posedge clock) disable iff (reset)
      item_en && header_open_ff && item.mode != MODE_HDR
      |=> $stable(ring_position_ff) && header_open_ff)
      else $error("data byte moved the ring while a header was open");

endmodule

[sv/rolling_key_byte_cipher.sv]
// Top level of the rolling key byte cipher: request register, core and response register.
//
// Flow: an accepted request waits in the request register until the response register
// is free or being emptied, then the core transforms it into the response register.
// Throughput: one transaction per cycle unless the sink stalls; the key ring update is
// a single register read-modify-write; a request can enter while a response waits.
// Reset: synchronous, active high; the key ring clears to zero, length 9, position 0,
// no header open, and both pipeline registers empty.
module rolling_key_byte_cipher (
   input  logic       clock,
   input  logic       reset,
   rkbc_req_if.sink   req_ch,
   rkbc_rsp_if.source rsp_ch
);
   import rkbc_pkg::*;

   // Request register: holds one accepted transaction until the core consumes it.
   logic       in_valid_ff;
   item_type   in_item_ff;
   item_type   in_item_in;

   // Response register: holds one finished result until the sink takes it.
   logic       out_valid_ff;
   result_type out_res_ff;

   result_type core_res;
   logic       advance;
   logic       req_fire;

   // The held request moves through the core whenever the response register is free
   // or is being emptied in this same cycle. Key state updates only on that move, so
   // a stalled response never lets the ring run ahead of the delivered results.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_fire = req_ch.valid && req_ch.ready;

   // The request register accepts a new transaction when empty or when its content
   // is leaving this cycle, which gives one transaction per cycle in steady flow.
   assign req_ch.ready = !in_valid_ff || advance;

   assign in_item_in.mode         = req_ch.mode;
   assign in_item_in.header_start = req_ch.header_start;
   assign in_item_in.data_in      = req_ch.data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= in_item_in;
      end
   end

   rkbc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .item_en (advance),
      .item    (in_item_ff),
      .res     (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= core_res;
      end
   end

   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.data_out = out_res_ff.data_out;
   assign rsp_ch.status   = out_res_ff.status;
   assign rsp_ch.key_size = out_res_ff.key_size;

endmodule

[tb/tb_top.sv]
// Self-checking testbench of the rolling key byte cipher with its own key ring predictor.
`timescale 1ns / 100ps

module tb_top;
   import rkbc_pkg::*;

   // Mode code 3 is not used by the block; it must be answered as ignored.
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Length of the long receiver hold-off, in clock cycles.
   localparam int HOLD_CYCLES = 120;

   // Number of mismatches that are reported in full before only counting them.
   localparam int SHOWN_FAULTS = 10;

   // The stimulus stream holds byte transactions and markers that steer the driver.
   typedef enum logic [1:0] {STEP_ITEM, STEP_PHASE, STEP_HOLD, STEP_DRAIN} step_kind_type;

   typedef struct {
      step_kind_type kind;
      item_type      item;
      int            send_pct;
      int            recv_pct;
   } stream_step_type;

   logic clock = 1'b0;
   logic reset;

   rkbc_req_if req_ch ();
   rkbc_rsp_if rsp_ch ();

   rolling_key_byte_cipher DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // A 12 ns clock period, low half first.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Pending stimulus and the responses that accepted transactions are owed.
   stream_step_type stream_q [$];
   result_type      awaited_rsp [$];

   // The predictor's own copy of the key ring and the header tracking state.
   logic [BYTE_W-1:0] key_copy [RING_DEPTH];
   logic [LEN_W-1:0]  copy_len;
   logic [LEN_W-1:0]  copy_pos;
   logic [LEN_W-1:0]  copy_count;
   logic              copy_open;

   // Idling percentages of the current phase and the hold-off requests.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;
   int holds_served   = 0;
   int hold_left      = 0;

   // Set at each rising edge when the request transaction was accepted there.
   logic req_taken = 1'b0;

   // Bookkeeping for the checks and the closing summary.
   int fault_count  = 0;
   int rsp_count    = 0;
   int live_items   = 0;
   int status_tally [5] = '{default: 0};

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // A check byte is the previous byte times nine, exclusive-ored with the
   // length factor times thirty, both taken modulo 256.
   function automatic logic [BYTE_W-1:0] chain_byte(input logic [BYTE_W-1:0] prev,
                                                    input logic [LEN_W-1:0]  factor);
      logic [15:0] scaled;
      logic [15:0] stepped;
      scaled  = 16'(prev) * 16'(CHECK_MUL);
      stepped = 16'(factor) * 16'(CHECK_STEP);
      return scaled[BYTE_W-1:0] ^ stepped[BYTE_W-1:0];
   endfunction

   // Stores one header byte in the ring copy. Once the whole header is in,
   // the two check bytes are tested and the position returns to zero
   // whether the test passed or not.
   function automatic logic [STATUS_W-1:0] take_header_byte(input logic              start,
                                                            input logic [BYTE_W-1:0] value);
      logic [LEN_W-1:0] len;
      logic             sealed;
      if (start) begin
         copy_count = '0;
         copy_open  = 1'b1;
      end else if (!copy_open) begin
         return ST_IGNORED;
      end
      if (copy_count >= DEPTH_L) begin
         copy_count = '0;
      end
      key_copy[copy_count] = value;
      copy_count++;
      // The fifth header byte chooses between the short and the long ring.
      if (copy_count == LEN_SEL_COUNT) begin
         copy_len = value[0] ? LEN_LONG : LEN_SHORT;
      end
      if (copy_count < LEN_SEL_COUNT || copy_count < copy_len) begin
         return ST_TAKEN;
      end
      len    = copy_len;
      sealed = key_copy[len - 4'd1] == chain_byte(key_copy[len - 4'd2], len + 4'd1) &&
               key_copy[len - 4'd2] == chain_byte(key_copy[len - 4'd3], len);
      copy_open  = 1'b0;
      copy_count = '0;
      copy_pos   = '0;
      return sealed ? ST_OK : ST_FAIL;
   endfunction

   // Works out the response of one accepted transaction and advances the copy.
   function automatic result_type cipher_response(input item_type it);
      result_type        r;
      logic [LEN_W-1:0]  pos;
      logic [LEN_W-1:0]  nxt;
      logic [BYTE_W-1:0] k;
      r.data_out = '0;
      r.status   = ST_IGNORED;
      case (it.mode)
         MODE_HDR: begin
            r.status = take_header_byte(it.header_start, it.data_in);
         end
         MODE_ENC, MODE_DEC: begin
            // Data is only transformed while no header is being loaded.
            if (!copy_open) begin
               pos = (copy_pos >= copy_len || copy_pos >= DEPTH_L) ? '0 : copy_pos;
               nxt = pos + 1'b1;
               if (nxt >= copy_len || nxt >= DEPTH_L) begin
                  nxt = '0;
               end
               k             = key_copy[pos] ^ (key_copy[nxt] + KEY_ADD);
               key_copy[pos] = k;
               copy_pos      = nxt;
               r.data_out    = (it.mode == MODE_ENC) ? it.data_in + k : it.data_in - k;
               r.status      = ST_DATA;
            end
         end
         default: begin
         end
      endcase
      r.key_size = copy_len;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus construction
   // ------------------------------------------------------------------------

   task automatic queue_byte(input logic [MODE_W-1:0] mode, input logic start,
                             input logic [BYTE_W-1:0] value);
      stream_step_type s;
      s.kind              = STEP_ITEM;
      s.item.mode         = mode;
      s.item.header_start = start;
      s.item.data_in      = value;
      s.send_pct          = 0;
      s.recv_pct          = 0;
      stream_q.push_back(s);
   endtask

   task automatic queue_marker(input step_kind_type kind, input int send_pct,
                               input int recv_pct);
      stream_step_type s;
      s.kind     = kind;
      s.item     = '0;
      s.send_pct = send_pct;
      s.recv_pct = recv_pct;
      stream_q.push_back(s);
   endtask

   // Data bytes favour the extremes now and then so that carries and borrows
   // at both ends of the byte range are exercised.
   function automatic logic [BYTE_W-1:0] data_value();
      if ($urandom_range(7) == 0) begin
         return $urandom_range(1) ? 8'hFF : 8'h00;
      end
      return 8'($urandom);
   endfunction

   task automatic queue_data_burst(input int count);
      for (int i = 0; i < count; i++) begin
         queue_byte($urandom_range(1) ? MODE_ENC : MODE_DEC, 1'($urandom), data_value());
         live_items++;
      end
   endtask

   // Queues a complete header of the given length. Its check bytes are built
   // to pass unless spoilt is set, in which case one bit of one of the last
   // three bytes is flipped. A data byte may be slipped in before the byte at
   // stray_at; the block has to ignore it as a header is open.
   task automatic queue_header(input int len, input bit spoilt, input int stray_at);
      logic [BYTE_W-1:0] hb [RING_DEPTH];
      int                flip;
      foreach (hb[i]) begin
         hb[i] = 8'($urandom);
      end
      hb[4][0]    = (len == RING_DEPTH);
      hb[len - 2] = chain_byte(hb[len - 3], LEN_W'(len));
      hb[len - 1] = chain_byte(hb[len - 2], LEN_W'(len + 1));
      if (spoilt) begin
         flip     = $urandom_range(len - 1, len - 3);
         hb[flip] = hb[flip] ^ 8'(1 << $urandom_range(7));
      end
      for (int i = 0; i < len; i++) begin
         if (i == stray_at) begin
            queue_byte($urandom_range(1) ? MODE_ENC : MODE_DEC, 1'($urandom), 8'($urandom));
         end
         queue_byte(MODE_HDR, i == 0, hb[i]);
         live_items++;
      end
   endtask

   // Mostly whole sessions (an optional abandoned header start, a header,
   // then a run of data), with some bare data runs and some ignored noise.
   task automatic queue_random_traffic(input int amount);
      int goal;
      int pick;
      int part;
      goal = live_items + amount;
      while (live_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            if (pick[0]) begin
               queue_byte(MODE_UNUSED, 1'($urandom), 8'($urandom));
            end else begin
               queue_byte(MODE_HDR, 1'b0, 8'($urandom));
            end
         end else if (pick < 25) begin
            queue_data_burst($urandom_range(1, 24));
         end else begin
            // A partial header of at most eight bytes never completes, and
            // the header that follows restarts the load.
            if ($urandom_range(4) == 0) begin
               part = $urandom_range(1, 8);
               for (int i = 0; i < part; i++) begin
                  queue_byte(MODE_HDR, i == 0, 8'($urandom));
                  live_items++;
               end
            end
            queue_header($urandom_range(10, 9), $urandom_range(6) == 0,
                         ($urandom_range(3) == 0) ? $urandom_range(1, 8) : -1);
            queue_data_burst($urandom_range(1, 24));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Driver: presents the next transaction at the falling edge.
   // ------------------------------------------------------------------------

   // The request fields only move once the current transaction has been
   // taken, and each signal receives a single update per falling edge, so a
   // valid that stays high across back-to-back transactions never dips.
   always @(negedge clock) begin : drive_requests
      logic     next_valid;
      item_type next_item;
      bit       settled;
      next_valid = req_ch.valid;
      next_item  = '{mode: req_ch.mode, header_start: req_ch.header_start,
                     data_in: req_ch.data_in};
      settled    = 1'b0;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         next_valid = 1'b0;
         while (!settled && stream_q.size() > 0) begin
            case (stream_q[0].kind)
               STEP_PHASE: begin
                  send_idle_pct  = stream_q[0].send_pct;
                  recv_stall_pct = stream_q[0].recv_pct;
                  void'(stream_q.pop_front());
               end
               STEP_HOLD: begin
                  holds_asked++;
                  void'(stream_q.pop_front());
               end
               STEP_DRAIN: begin
                  // The sender rests here until every owed response is in.
                  if (awaited_rsp.size() == 0) begin
                     void'(stream_q.pop_front());
                  end else begin
                     settled = 1'b1;
                  end
               end
               default: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     next_valid = 1'b1;
                     next_item  = stream_q[0].item;
                     void'(stream_q.pop_front());
                  end
                  settled = 1'b1;
               end
            endcase
         end
      end
      req_ch.valid        <= next_valid;
      req_ch.mode         <= next_item.mode;
      req_ch.header_start <= next_item.header_start;
      req_ch.data_in      <= next_item.data_in;
   end

   // ------------------------------------------------------------------------
   // Receiver: random back-pressure plus the occasional long hold-off.
   // ------------------------------------------------------------------------

   always @(negedge clock) begin : pace_responses
      logic next_ready;
      if (reset) begin
         next_ready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left  = HOLD_CYCLES - 1;
         next_ready = 1'b0;
      end else begin
         next_ready = $urandom_range(99) >= recv_stall_pct;
      end
      rsp_ch.ready <= next_ready;
   end

   // ------------------------------------------------------------------------
   // Monitor and scoreboard, sampling at the rising edge.
   // ------------------------------------------------------------------------

   task automatic log_fault(input string what);
      fault_count++;
      if (fault_count <= SHOWN_FAULTS) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin : observe
      result_type got;
      result_type want;
      item_type   seen;
      if (reset) begin
         foreach (key_copy[i]) begin
            key_copy[i] = '0;
         end
         copy_len   = LEN_SHORT;
         copy_pos   = '0;
         copy_count = '0;
         copy_open  = 1'b0;
         req_taken  = 1'b0;
      end else begin
         // A response is checked against the oldest owed one before this
         // edge's request is predicted, which keeps the order strictly FIFO.
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.data_out = rsp_ch.data_out;
            got.status   = rsp_ch.status;
            got.key_size = rsp_ch.key_size;
            if (awaited_rsp.size() == 0) begin
               log_fault($sformatf("response with none owed: data_out %0d status %0d key_size %0d",
                                   got.data_out, got.status, got.key_size));
            end else begin
               want = awaited_rsp.pop_front();
               rsp_count++;
               status_tally[want.status]++;
               if (got.data_out !== want.data_out) begin
                  log_fault($sformatf("response %0d data_out expected %0d, got %0d",
                                      rsp_count, want.data_out, got.data_out));
               end
               if (got.status !== want.status) begin
                  log_fault($sformatf("response %0d status expected %0d, got %0d",
                                      rsp_count, want.status, got.status));
               end
               if (got.key_size !== want.key_size) begin
                  log_fault($sformatf("response %0d key_size expected %0d, got %0d",
                                      rsp_count, want.key_size, got.key_size));
               end
            end
         end
         req_taken = req_ch.valid && req_ch.ready;
         if (req_taken) begin
            seen.mode         = req_ch.mode;
            seen.header_start = req_ch.header_start;
            seen.data_in      = req_ch.data_in;
            awaited_rsp.push_back(cipher_response(seen));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus plan, reset and end of test.
   // ------------------------------------------------------------------------

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.mode         = MODE_HDR;
      req_ch.header_start = 1'b0;
      req_ch.data_in      = '0;
      rsp_ch.ready        = 1'b0;

      // First phase: neither side idles.
      queue_marker(STEP_PHASE, 0, 0);

      // Directed opening. A data byte before any header uses the all-zero
      // ring of length nine; a header byte without a start and the unused
      // mode are both ignored.
      queue_byte(MODE_ENC, 1'b0, 8'h00);
      queue_byte(MODE_HDR, 1'b0, 8'hFF);
      queue_byte(MODE_UNUSED, 1'b1, 8'hA5);
      // A lone header start that is dropped by the restart of the next header,
      // which then fails its check on the short ring.
      queue_byte(MODE_HDR, 1'b1, 8'hFF);
      queue_header(9, 1'b1, -1);
      // Data after a failed check still runs on the loaded ring from position zero.
      queue_byte(MODE_DEC, 1'b0, 8'hFF);
      // A good long header with a data byte inside it that must be ignored.
      queue_header(10, 1'b0, 6);
      queue_byte(MODE_ENC, 1'b1, 8'hFF);

      // The receiver stops for a long stretch while the sender keeps offering
      // data, so the block fills up and pushes back on its input.
      queue_marker(STEP_HOLD, 0, 0);
      queue_data_burst(40);
      queue_random_traffic(110);
      queue_marker(STEP_DRAIN, 0, 0);

      // Remaining phases: idle sender, stalling receiver, then both.
      queue_marker(STEP_PHASE, 67, 0);
      queue_random_traffic(150);
      queue_marker(STEP_DRAIN, 0, 0);
      queue_marker(STEP_PHASE, 0, 67);
      queue_random_traffic(150);
      queue_marker(STEP_DRAIN, 0, 0);
      queue_marker(STEP_PHASE, 32, 32);
      queue_random_traffic(150);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the stream to run dry and for every owed response, then keep the clock
      // running so that the two-stage pipeline can show any stray output.
      do @(negedge clock);
      while (stream_q.size() != 0 || req_ch.valid || awaited_rsp.size() != 0);
      repeat (8) @(negedge clock);

      $display("Covered %0d transactions over four idling phases: %0d data bytes, %0d header bytes",
               rsp_count, status_tally[ST_DATA], status_tally[ST_TAKEN]);
      $display("taken, %0d headers passed and %0d failed their check, %0d ignored; %0d mismatches.",
               status_tally[ST_OK], status_tally[ST_FAIL], status_tally[ST_IGNORED], fault_count);
      if (fault_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #2_000_000;
      $display("Timed out with %0d responses still owed.", awaited_rsp.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule

[filelist.f]
sv/rkbc_pkg.sv
sv/rkbc_req_if.sv
sv/rkbc_core.sv
sv/rolling_key_byte_cipher.sv
tb/tb_top.sv
